>>> rtl/core/bir_pkg.sv
`timescale 1ns / 1ps
package bir_pkg;
	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 256;
	localparam int MAX_CHANNELS = 4;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * (1 << CW);
	localparam int AW    = XW + YW + CW;

	// register indexes
	localparam logic [2:0] REG_IN_W  = 3'd0;
	localparam logic [2:0] REG_IN_H  = 3'd1;
	localparam logic [2:0] REG_OUT_W = 3'd2;
	localparam logic [2:0] REG_OUT_H = 3'd3;
	localparam logic [2:0] REG_CHAN  = 3'd4;

	localparam logic ACT_STORE   = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVX,
		ST_DIVY,
		ST_WGT,
		ST_RD,
		ST_DIVA,
		ST_EMIT
	} state_t;
endpackage

>>> rtl/core/bir_ram.sv
`timescale 1ns / 1ps
module bir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/bilinear_image_rescaler.sv
`timescale 1ns / 1ps
// Store request: accepted back to back, no result.
// Compute request: a multiply, divider passes for the source x and y position, a weight
// step, then per channel frame store reads of the taps, a divider pass and an emit step
// that waits while a held result is not taken; the shared divider yields 1 bit per cycle.
// Reset (async, arst_n low) clears control and restores the register defaults;
// the frame store is not cleared and holds garbage until written.
module bilinear_image_rescaler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [1:0]  chan,
	input  logic [15:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_value,
	output logic [1:0]  out_chan,
	output logic        last
);
	import bir_pkg::*;

	// configuration registers
	logic [8:0] in_w_q, in_h_q, out_w_q, out_h_q;
	logic [2:0] chan_cnt_q;

	// effective (clamped) sizes
	logic [8:0] wi, hi, wo, ho;
	logic [2:0] cc;

	state_t state_q, state_d;

	logic [7:0]  col_q, row_q;
	logic [15:0] ny_q;
	logic [7:0]  x0_q, x1_q, y0_q, y1_q;
	logic [7:0]  rx_q, ry_q;
	logic [16:0] wa_q, wb_q, wc_q, wd_q, den_q;
	logic [1:0]  ch_q;
	logic [2:0]  k_q;
	logic [31:0] acc_q;

	// shared restoring divider
	logic [16:0] rem_q, dsr_q;
	logic [15:0] dlo_q, quo_q;
	logic [3:0]  cnt_q;
	logic [17:0] trial;
	logic        fits;
	logic [16:0] rem_nx;
	logic [15:0] quo_nx;

	logic        out_valid_q, out_last_q;
	logic [15:0] out_val_q;
	logic [1:0]  out_ch_q;

	// frame store
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [15:0]   ram_rdata;

	logic        in_acc, div_done, emit_go, ch_last;
	logic [7:0]  rd_x, rd_y;
	logic [16:0] wsel;
	logic [32:0] prod;
	logic [8:0]  wim1, him1;

	bir_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(sample),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_w_q     <= 9'd256;
			in_h_q     <= 9'd256;
			out_w_q    <= 9'd256;
			out_h_q    <= 9'd256;
			chan_cnt_q <= 3'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IN_W:  in_w_q     <= cfg_data;
				REG_IN_H:  in_h_q     <= cfg_data;
				REG_OUT_W: out_w_q    <= cfg_data;
				REG_OUT_H: out_h_q    <= cfg_data;
				REG_CHAN:  chan_cnt_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		wi = (in_w_q < 9'd2) ? 9'd2 : (in_w_q > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : in_w_q;
		hi = (in_h_q < 9'd2) ? 9'd2 : (in_h_q > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : in_h_q;
		wo = (out_w_q == 9'd0) ? 9'd1 : out_w_q;
		ho = (out_h_q == 9'd0) ? 9'd1 : out_h_q;
		cc = (chan_cnt_q == 3'd0) ? 3'd1 :
			(chan_cnt_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chan_cnt_q;
		wim1 = wi - 9'd1;
		him1 = hi - 9'd1;
	end

	// divider step: one quotient bit per cycle
	always_comb begin
		trial  = {rem_q, dlo_q[15]};
		fits   = (trial >= {1'b0, dsr_q});
		rem_nx = fits ? 17'(trial - {1'b0, dsr_q}) : trial[16:0];
		quo_nx = {quo_q[14:0], fits};
	end

	assign in_acc   = in_valid && in_ready;
	assign div_done = (cnt_q == 4'd15);
	assign emit_go  = !out_valid_q || out_ready;
	assign ch_last  = ({1'b0, ch_q} == 3'(cc - 3'd1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && action == ACT_COMPUTE) state_d = ST_MUL;
			ST_MUL:  state_d = ST_DIVX;
			ST_DIVX: if (div_done) state_d = ST_DIVY;
			ST_DIVY: if (div_done) state_d = ST_WGT;
			ST_WGT:  state_d = ST_RD;
			ST_RD:   if (k_q == 3'd4) state_d = ST_DIVA;
			ST_DIVA: if (div_done) state_d = ST_EMIT;
			ST_EMIT: if (emit_go) state_d = ch_last ? ST_IDLE : ST_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		ram_we    = in_acc && (action == ACT_STORE);
		ram_waddr = {row[YW-1:0], col[XW-1:0], chan[CW-1:0]};
		rd_x      = k_q[0] ? x1_q : x0_q;
		rd_y      = k_q[1] ? y1_q : y0_q;
		ram_raddr = {rd_y[YW-1:0], rd_x[XW-1:0], ch_q[CW-1:0]};
		case (k_q)
			3'd1:    wsel = wa_q;
			3'd2:    wsel = wb_q;
			3'd3:    wsel = wc_q;
			default: wsel = wd_q;
		endcase
		prod = ram_rdata * wsel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 4'd0;
			k_q         <= 3'd0;
			ch_q        <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && emit_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_DIVX, ST_DIVY, ST_DIVA: cnt_q <= cnt_q + 4'd1;
				default: cnt_q <= 4'd0;
			endcase
			case (state_q)
				ST_IDLE: ch_q <= 2'd0;
				ST_RD:   k_q <= (k_q == 3'd4) ? 3'd0 : k_q + 3'd1;
				ST_EMIT: if (emit_go) ch_q <= ch_q + 2'd1;
				default: k_q <= 3'd0;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q <= col;
			row_q <= row;
		end
		// divider steps; the last x step reloads the divider for y below
		if (state_q == ST_DIVY || state_q == ST_DIVA ||
				(state_q == ST_DIVX && !div_done)) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			dlo_q <= {dlo_q[14:0], 1'b0};
		end
		case (state_q)
			ST_MUL: begin
				ny_q  <= 16'(him1 * row_q);
				rem_q <= 17'd0;
				dlo_q <= 16'(wim1 * col_q);
				dsr_q <= {8'd0, wo};
			end
			ST_DIVX: if (div_done) begin
				rx_q  <= rem_nx[7:0];
				x0_q  <= (quo_nx > 16'(wim1)) ? wim1[7:0] : quo_nx[7:0];
				x1_q  <= ({1'b0, quo_nx} + 17'd1 > 17'(wim1)) ? wim1[7:0] :
					8'(quo_nx + 16'd1);
				rem_q <= 17'd0;
				dlo_q <= ny_q;
				dsr_q <= {8'd0, ho};
			end
			ST_DIVY: if (div_done) begin
				ry_q <= rem_nx[7:0];
				y0_q <= (quo_nx > 16'(him1)) ? him1[7:0] : quo_nx[7:0];
				y1_q <= ({1'b0, quo_nx} + 17'd1 > 17'(him1)) ? him1[7:0] :
					8'(quo_nx + 16'd1);
			end
			ST_WGT: begin
				wa_q  <= 17'((wo - {1'b0, rx_q}) * (ho - {1'b0, ry_q}));
				wb_q  <= 17'(rx_q * (ho - {1'b0, ry_q}));
				wc_q  <= 17'((wo - {1'b0, rx_q}) * ry_q);
				wd_q  <= 17'(rx_q * ry_q);
				den_q <= 17'(wo * ho);
			end
			ST_RD: begin
				// read data of tap k-1 lands while tap k is addressed
				if (k_q == 3'd0) acc_q <= 32'd0;
				else acc_q <= acc_q + prod[31:0];
				if (k_q == 3'd4) begin
					rem_q <= {1'b0, 16'((acc_q + prod[31:0]) >> 16)};
					dlo_q <= 16'(acc_q + prod[31:0]);
					dsr_q <= den_q;
				end
			end
			// quotient waits in quo_q so a held result keeps its value
			ST_EMIT: if (emit_go) begin
				out_val_q  <= quo_q;
				out_ch_q   <= ch_q;
				out_last_q <= ch_last;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = out_val_q;
	assign out_chan    = out_ch_q;
	assign last        = out_last_q;
endmodule
